// File: src/packet_deframer_defines.svh
// packet_deframer_defines.svh: assertion macros used by the deframer parser RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef PACKET_DEFRAMER_DEFINES_SVH
`define PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PKD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pkd_pkg.sv
// pkd_pkg.sv: types and constants for the packet deframer.
// No dependencies; imported by every deframer module.
`default_nettype none

package pkd_pkg;

    // Frame marker and trailer characters
    localparam logic [7:0] CH_K  = 8'h4B;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Header plus trailer bytes: the smallest legal total length
    localparam logic [9:0] MIN_LEN = 10'd8;

    // Packed width of the master-side tdata (52 bits of fields, byte padded)
    localparam int unsigned TDATA_W = 56;

    typedef enum logic [3:0] {
        PH_HUNT_K,
        PH_HUNT_S,
        PH_LEN_LO,
        PH_TYPE,
        PH_PARAM1,
        PH_PARAM2,
        PH_PAYLOAD,
        PH_CR,
        PH_LF_GOOD,
        PH_LF_BAD
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_TRAILER = 2'd2
    } t_status;

    // One result beat
    typedef struct packed {
        logic        packet_end;
        logic [7:0]  payload_byte;
        logic [9:0]  byte_index;
        t_status     status;
        logic [5:0]  type_code;
        logic [7:0]  param_first;
        logic [7:0]  param_second;
        logic [9:0]  total_length;
    } t_result;

endpackage

`default_nettype wire

// File: src/pkd_in_stage.sv
// pkd_in_stage.sv: input register for received bytes.
// Depends on pkd_pkg.
`default_nettype none

module pkd_in_stage
    import pkd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_data
);

    logic       r_valid;
    logic [7:0] r_data;

    // Take a new beat when empty or when the held one leaves
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: src/pkd_parser.sv
// pkd_parser.sv: frame state machine; one byte in, at most one result out.
// Depends on pkd_pkg and packet_deframer_defines.svh.
`default_nettype none
`include "packet_deframer_defines.svh"

module pkd_parser
    import pkd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output t_result         o_res
);

    t_phase     r_phase,       n_phase;
    logic [9:0] r_len,         n_len;
    logic [9:0] r_count,       n_count;
    logic [5:0] r_type,        n_type;
    logic [7:0] r_param_first, n_param_first;
    logic [7:0] r_param_second, n_param_second;

    logic       fire;
    logic       emit;
    logic       res_end;
    logic [7:0] res_byte;
    logic [9:0] res_index;
    t_status    res_status;
    logic [9:0] payload_len;

    // A byte is consumed whenever the result register can take a beat
    assign o_in_ready = i_res_ready;
    assign fire       = i_in_valid && i_res_ready;
    assign payload_len = r_len - MIN_LEN;

    // Next state and result
    always_comb begin
        n_phase        = r_phase;
        n_len          = r_len;
        n_count        = r_count;
        n_type         = r_type;
        n_param_first  = r_param_first;
        n_param_second = r_param_second;
        emit       = 1'b0;
        res_end    = 1'b0;
        res_byte   = 8'd0;
        res_index  = 10'd0;
        res_status = ST_OK;
        case (r_phase)
            PH_HUNT_K: begin
                if (i_in_byte == CH_K) n_phase = PH_HUNT_S;
            end
            PH_HUNT_S: begin
                if (i_in_byte == CH_S)      n_phase = PH_LEN_LO;
                else if (i_in_byte != CH_K) n_phase = PH_HUNT_K;
            end
            PH_LEN_LO: begin
                n_len          = {2'b00, i_in_byte};
                n_type         = 6'd0;
                n_param_first  = 8'd0;
                n_param_second = 8'd0;
                n_count        = 10'd0;
                n_phase        = PH_TYPE;
            end
            PH_TYPE: begin
                n_len  = {i_in_byte[7:6], r_len[7:0]};
                n_type = i_in_byte[5:0];
                if (n_len < MIN_LEN) begin
                    n_phase    = PH_HUNT_K;
                    emit       = 1'b1;
                    res_end    = 1'b1;
                    res_status = ST_SHORT;
                end else begin
                    n_phase = PH_PARAM1;
                end
            end
            PH_PARAM1: begin
                n_param_first = i_in_byte;
                n_phase       = PH_PARAM2;
            end
            PH_PARAM2: begin
                n_param_second = i_in_byte;
                n_count        = 10'd0;
                n_phase        = (r_len > MIN_LEN) ? PH_PAYLOAD : PH_CR;
            end
            PH_PAYLOAD: begin
                emit      = 1'b1;
                res_byte  = i_in_byte;
                res_index = r_count;
                n_count   = r_count + 10'd1;
                if (n_count >= payload_len) n_phase = PH_CR;
            end
            PH_CR: begin
                n_phase = (i_in_byte == CH_CR) ? PH_LF_GOOD : PH_LF_BAD;
            end
            PH_LF_GOOD, PH_LF_BAD: begin
                emit       = 1'b1;
                res_end    = 1'b1;
                res_status = ((r_phase == PH_LF_GOOD) && (i_in_byte == CH_LF))
                             ? ST_OK : ST_TRAILER;
                n_phase    = PH_HUNT_K;
            end
            default: begin
                n_phase = PH_HUNT_K;
            end
        endcase
    end

    // Result carries the header fields as updated by this byte
    assign o_res_valid = fire && emit;
    always_comb begin
        o_res.packet_end   = res_end;
        o_res.payload_byte = res_byte;
        o_res.byte_index   = res_index;
        o_res.status       = res_status;
        o_res.type_code    = n_type;
        o_res.param_first  = n_param_first;
        o_res.param_second = n_param_second;
        o_res.total_length = n_len;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT_K;
            r_len          <= 10'd0;
            r_count        <= 10'd0;
            r_type         <= 6'd0;
            r_param_first  <= 8'd0;
            r_param_second <= 8'd0;
        end else if (fire) begin
            r_phase        <= n_phase;
            r_len          <= n_len;
            r_count        <= n_count;
            r_type         <= n_type;
            r_param_first  <= n_param_first;
            r_param_second <= n_param_second;
        end
    end

    // Checks
    `PKD_ASSERT_NOW(a_payload_phase, o_res_valid && !o_res.packet_end,
        r_phase == PH_PAYLOAD, "payload beat outside payload phase")
    `PKD_ASSERT_NOW(a_short_from_type, o_res_valid && (o_res.status == ST_SHORT),
        (r_phase == PH_TYPE) && (o_res.total_length < MIN_LEN), "short status misplaced")
    `PKD_ASSERT_NOW(a_end_phase, o_res_valid && o_res.packet_end,
        (r_phase == PH_TYPE) || (r_phase == PH_LF_GOOD) || (r_phase == PH_LF_BAD),
        "packet end from wrong phase")
    `PKD_ASSERT_NEXT(a_count_cleared, fire && (r_phase == PH_PARAM2),
        r_count == 10'd0, "payload index not cleared")
    `PKD_ASSERT_NOW(a_index_bound, o_res_valid && !o_res.packet_end,
        r_count < payload_len, "payload index past payload length")

endmodule

`default_nettype wire

// File: src/pkd_out_stage.sv
// pkd_out_stage.sv: result register in front of the master-side stream.
// Depends on pkd_pkg.
`default_nettype none

module pkd_out_stage
    import pkd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_result i_res,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // Accept when empty or when the held beat is taken this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: src/packet_deframer.sv
// packet_deframer: recovers 'K','S' framed packets from a byte stream.
// Path: a slave-side beat passes the input register, the frame state machine and the result register.
// Throughput: one byte per cycle while m_axis_tready holds; the input register, frame state
// machine and result register each pass a beat every cycle unless the master side stalls.
// Reset: synchronous, active low; state returns to hunting for 'K', both
// stream registers empty.
`default_nettype none

module packet_deframer
    import pkd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // slave side
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    // master side
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [7:0] payload_byte, [17:8] byte_index,
                                                    // [19:18] status, [25:20] type_code,
                                                    // [33:26] param_first,
                                                    // [41:34] param_second,
                                                    // [51:42] total_length, [55:52] zero
    output logic                    m_axis_tuser    // [0] packet_end
);

    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       res_valid;
    logic       res_ready;
    t_result    res;
    t_result    out_res;

    pkd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (in_valid),
        .i_ready (in_ready),
        .o_data  (in_byte)
    );

    pkd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_byte   (in_byte),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    pkd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    // Pack the result beat, first field lowest
    assign m_axis_tdata = {4'd0,
                           out_res.total_length,
                           out_res.param_second,
                           out_res.param_first,
                           out_res.type_code,
                           out_res.status,
                           out_res.byte_index,
                           out_res.payload_byte};
    assign m_axis_tuser = out_res.packet_end;

endmodule

`default_nettype wire
